### hdl/lsw_pkg.sv
// types and constants shared by the line segment window clipper
// no dependencies
`default_nettype none
package lsw_pkg;

    localparam int ADDR_W    = 5;
    localparam int DEN_W     = 33;
    localparam int NUM_W     = 35;
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = 17;
    localparam int T_W       = 18;
    localparam int PROD_W    = 51;

    localparam logic [T_W-1:0] T_SAT = 18'd65537;

    localparam logic [2:0] REG_LEFT  = 3'd0;
    localparam logic [2:0] REG_TOP   = 3'd1;
    localparam logic [2:0] REG_COLS  = 3'd2;
    localparam logic [2:0] REG_ROWS  = 3'd3;
    localparam logic [2:0] REG_SCALE = 3'd4;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
    } t_seg_in;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] clipped_first_x;
        logic signed [31:0] clipped_first_y;
        logic signed [31:0] clipped_second_x;
        logic signed [31:0] clipped_second_y;
    } t_seg_out;

    typedef struct packed {
        logic signed [31:0] window_left;
        logic signed [31:0] window_top;
        logic [7:0]         cell_columns;
        logic [7:0]         cell_rows;
        logic [7:0]         cell_scale;
    } t_cfg;

    // per item data carried alongside the dividers
    typedef struct packed {
        t_seg_in            seg;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [1:0]         d_pos;
        logic [1:0]         d_neg;
        logic [3:0]         q_neg;
    } t_side;

endpackage
`default_nettype wire

### hdl/line_segment_window_clip.sv
// top level of the line segment window clipper
// depends on lsw_pkg, lsw_cfg, lsw_front, lsw_div, lsw_delay, lsw_back
`default_nettype none
// Liang-Barsky clipping of one segment per clock, when no stall holds the
// pipeline, against the window set by the configuration registers; coordinates
// are signed Q16.16. Every request gives exactly one result, offered on the
// output after 25 register stages in all: 3 front stages, a 17-stage
// restoring divider (one quotient bit per stage, four in parallel, one per
// window edge) and 5 back stages for the range test and interpolation. The
// whole pipeline holds while a result waits under stall, so o_in_stall follows
// i_out_stall when the output register is full. Rejected segments come back
// unchanged with visible low.
module line_segment_window_clip (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  lsw_pkg::t_seg_in           i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output lsw_pkg::t_seg_out          o_out_data,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [lsw_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lsw_pkg::*;

    t_cfg             w_cfg;
    logic             w_en;
    logic             w_f_vld, w_d_vld;
    t_side            w_f_side, w_d_side;
    logic [NUM_W-1:0] w_num [4];
    logic [DEN_W-1:0] w_den [2];
    logic [QUO_W-1:0] w_quo [4];
    logic             w_sat [4];

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    lsw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lsw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_seg   (i_in_data),
        .i_cfg   (w_cfg),
        .o_vld   (w_f_vld),
        .o_side  (w_f_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    for (genvar e = 0; e < 4; e++) begin : g_div
        lsw_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[e]),
            .i_den (w_den[e/2]),
            .o_quo (w_quo[e]),
            .o_sat (w_sat[e])
        );
    end

    lsw_delay u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_side  (w_f_side),
        .o_vld   (w_d_vld),
        .o_side  (w_d_side)
    );

    lsw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_side  (w_d_side),
        .i_quo   (w_quo),
        .i_sat   (w_sat),
        .o_vld   (o_out_valid),
        .o_seg   (o_out_data)
    );

endmodule
`default_nettype wire

### hdl/lsw_cfg.sv
// configuration registers behind the apb-style port
// depends on lsw_pkg
`default_nettype none
module lsw_cfg (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [lsw_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lsw_pkg::t_cfg              o_cfg
);
    import lsw_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_left  <= '0;
            r_cfg.window_top   <= '0;
            r_cfg.cell_columns <= '0;
            r_cfg.cell_rows    <= '0;
            r_cfg.cell_scale   <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_LEFT:  r_cfg.window_left  <= pwdata;
                REG_TOP:   r_cfg.window_top   <= pwdata;
                REG_COLS:  r_cfg.cell_columns <= pwdata[7:0];
                REG_ROWS:  r_cfg.cell_rows    <= pwdata[7:0];
                REG_SCALE: r_cfg.cell_scale   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LEFT:  prdata = r_cfg.window_left;
            REG_TOP:   prdata = r_cfg.window_top;
            REG_COLS:  prdata = {24'd0, r_cfg.cell_columns};
            REG_ROWS:  prdata = {24'd0, r_cfg.cell_rows};
            REG_SCALE: prdata = {24'd0, r_cfg.cell_scale};
            default:   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### hdl/lsw_front.sv
// front stages: deltas, window bounds, edge distances and magnitudes
// depends on lsw_pkg
`default_nettype none
module lsw_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_vld,
    input  lsw_pkg::t_seg_in           i_seg,
    input  lsw_pkg::t_cfg              i_cfg,
    output logic                       o_vld,
    output lsw_pkg::t_side             o_side,
    output logic [lsw_pkg::NUM_W-1:0]  o_num [4],
    output logic [lsw_pkg::DEN_W-1:0]  o_den [2]
);
    import lsw_pkg::*;

    // stage a
    logic               r_a_vld;
    t_seg_in            r_a_seg;
    logic signed [32:0] r_a_dx, r_a_dy;
    logic signed [33:0] r_a_right, r_a_bottom;
    logic signed [31:0] r_a_left, r_a_top;
    logic [15:0]        n_span_x, n_span_y;

    assign n_span_x = i_cfg.cell_columns * i_cfg.cell_scale;
    assign n_span_y = i_cfg.cell_rows * i_cfg.cell_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_seg    <= i_seg;
            r_a_dx     <= 33'(i_seg.second_x) - 33'(i_seg.first_x);
            r_a_dy     <= 33'(i_seg.second_y) - 33'(i_seg.first_y);
            r_a_left   <= i_cfg.window_left;
            r_a_top    <= i_cfg.window_top;
            r_a_right  <= 34'(i_cfg.window_left) + $signed({2'b00, n_span_x, 16'd0});
            r_a_bottom <= 34'(i_cfg.window_top) + $signed({2'b00, n_span_y, 16'd0});
        end
    end

    // stage b
    logic               r_b_vld;
    t_seg_in            r_b_seg;
    logic signed [32:0] r_b_dx, r_b_dy;
    logic signed [34:0] r_b_q [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_seg  <= r_a_seg;
            r_b_dx   <= r_a_dx;
            r_b_dy   <= r_a_dy;
            r_b_q[0] <= 35'(r_a_seg.first_x) - 35'(r_a_left);
            r_b_q[1] <= 35'(r_a_right) - 35'(r_a_seg.first_x);
            r_b_q[2] <= 35'(r_a_seg.first_y) - 35'(r_a_top);
            r_b_q[3] <= 35'(r_a_bottom) - 35'(r_a_seg.first_y);
        end
    end

    // stage c
    logic r_c_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side.seg   <= r_b_seg;
            o_side.dx    <= r_b_dx;
            o_side.dy    <= r_b_dy;
            o_side.d_pos <= {r_b_dy > 33'sd0, r_b_dx > 33'sd0};
            o_side.d_neg <= {r_b_dy[32], r_b_dx[32]};
            for (int e = 0; e < 4; e++) begin
                o_side.q_neg[e] <= r_b_q[e][34];
                o_num[e]        <= r_b_q[e][34] ? NUM_W'(-r_b_q[e]) : NUM_W'(r_b_q[e]);
            end
            o_den[0] <= r_b_dx[32] ? DEN_W'(-r_b_dx) : DEN_W'(r_b_dx);
            o_den[1] <= r_b_dy[32] ? DEN_W'(-r_b_dy) : DEN_W'(r_b_dy);
        end
    end

    assign o_vld = r_c_vld;

endmodule
`default_nettype wire

### hdl/lsw_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
// depends on lsw_pkg
`default_nettype none
module lsw_div (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire [lsw_pkg::NUM_W-1:0]   i_num,
    input  wire [lsw_pkg::DEN_W-1:0]   i_den,
    output logic [lsw_pkg::QUO_W-1:0]  o_quo,
    output logic                       o_sat
);
    import lsw_pkg::*;

    logic [DEN_W-1:0] r_den [DIV_STEPS];
    logic [DEN_W-1:0] r_rem [DIV_STEPS];
    logic [QUO_W-1:0] r_quo [DIV_STEPS];
    logic             r_sat [DIV_STEPS];

    logic             n_ge0;
    logic [NUM_W-1:0] n_diff0;

    assign n_ge0   = i_num >= NUM_W'(i_den);
    assign n_diff0 = i_num - NUM_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_sat[0] <= i_num >= NUM_W'({i_den, 1'b0});
            r_rem[0] <= n_ge0 ? n_diff0[DEN_W-1:0] : i_num[DEN_W-1:0];
            r_quo[0] <= QUO_W'(n_ge0);
        end
    end

    for (genvar k = 1; k < DIV_STEPS; k++) begin : g_step
        logic [DEN_W:0] n_two;
        logic [DEN_W:0] n_diff;
        logic           n_ge;

        assign n_two  = {r_rem[k-1], 1'b0};
        assign n_ge   = n_two >= {1'b0, r_den[k-1]};
        assign n_diff = n_two - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
                r_rem[k] <= n_ge ? n_diff[DEN_W-1:0] : n_two[DEN_W-1:0];
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], n_ge};
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];
    assign o_sat = r_sat[DIV_STEPS-1];

endmodule
`default_nettype wire

### hdl/lsw_delay.sv
// delay line that keeps item data and valid in step with the dividers
// depends on lsw_pkg
`default_nettype none
module lsw_delay (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  wire             i_vld,
    input  lsw_pkg::t_side  i_side,
    output logic            o_vld,
    output lsw_pkg::t_side  o_side
);
    import lsw_pkg::*;

    logic  r_vld  [DIV_STEPS];
    t_side r_side [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule
`default_nettype wire

### hdl/lsw_back.sv
// back stages: parameter range, accept test, end point interpolation
// depends on lsw_pkg
`default_nettype none
module lsw_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_vld,
    input  lsw_pkg::t_side             i_side,
    input  wire [lsw_pkg::QUO_W-1:0]   i_quo [4],
    input  wire                        i_sat [4],
    output logic                       o_vld,
    output lsw_pkg::t_seg_out          o_seg
);
    import lsw_pkg::*;

    // stage 1: entering and leaving parameters
    logic           r1_vld, r1_rej;
    t_side          r1_side;
    logic [T_W-1:0] r1_tin, r1_tout;
    logic [T_W-1:0] n_mag [4];
    logic [3:0]     n_pneg, n_ppos;
    logic [T_W-1:0] n_tin, n_tout;
    logic           n_rej;

    always_comb begin
        n_pneg = {i_side.d_neg[1], i_side.d_pos[1], i_side.d_neg[0], i_side.d_pos[0]};
        n_ppos = {i_side.d_pos[1], i_side.d_neg[1], i_side.d_pos[0], i_side.d_neg[0]};
        n_tin  = '0;
        n_tout = T_W'(65536);
        n_rej  = 1'b0;
        for (int e = 0; e < 4; e++) begin
            n_mag[e] = i_sat[e] ? T_SAT : T_W'(i_quo[e]);
            if (n_pneg[e]) begin
                if (i_side.q_neg[e] && n_mag[e] > n_tin) n_tin = n_mag[e];
            end else if (n_ppos[e]) begin
                if (i_side.q_neg[e]) begin
                    n_tout = '0;
                    if (n_mag[e] != '0) n_rej = 1'b1;
                end else if (n_mag[e] < n_tout) begin
                    n_tout = n_mag[e];
                end
            end else if (i_side.q_neg[e]) begin
                n_rej = 1'b1;
            end
        end
    end

    // stage 2: accept test
    logic                 r2_vld, r2_ok;
    t_side                r2_side;
    logic [QUO_W-1:0]     r2_tin, r2_tout;

    // stage 3: partial products
    logic                 r3_vld, r3_ok;
    t_side                r3_side;
    logic [32:0]          r3_pl [4];
    logic signed [34:0]   r3_ph [4];
    logic [QUO_W-1:0]     n3_t [4];
    logic signed [32:0]   n3_d [4];

    always_comb begin
        n3_t[0] = r2_tin;  n3_d[0] = r2_side.dx;
        n3_t[1] = r2_tin;  n3_d[1] = r2_side.dy;
        n3_t[2] = r2_tout; n3_d[2] = r2_side.dx;
        n3_t[3] = r2_tout; n3_d[3] = r2_side.dy;
    end

    // stage 4: sum with rounding offset
    logic                     r4_vld, r4_ok;
    t_side                    r4_side;
    logic signed [PROD_W-1:0] r4_sum [4];

    // stage 5: output register
    logic        r5_vld;
    logic [31:0] n5_c [4];

    always_comb begin
        n5_c[0] = r4_side.seg.first_x + r4_sum[0][47:16];
        n5_c[1] = r4_side.seg.first_y + r4_sum[1][47:16];
        n5_c[2] = r4_side.seg.first_x + r4_sum[2][47:16];
        n5_c[3] = r4_side.seg.first_y + r4_sum[3][47:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_tin  <= n_tin;
            r1_tout <= n_tout;
            r1_rej  <= n_rej;

            r2_side <= r1_side;
            r2_ok   <= !r1_rej && (r1_tin <= r1_tout);
            r2_tin  <= r1_tin[QUO_W-1:0];
            r2_tout <= r1_tout[QUO_W-1:0];

            r3_side <= r2_side;
            r3_ok   <= r2_ok;
            for (int k = 0; k < 4; k++) begin
                r3_pl[k] <= n3_t[k] * n3_d[k][15:0];
                r3_ph[k] <= $signed({1'b0, n3_t[k]}) * $signed(n3_d[k][32:16]);
            end

            r4_side <= r3_side;
            r4_ok   <= r3_ok;
            for (int k = 0; k < 4; k++) begin
                r4_sum[k] <= $signed({r3_ph[k], 16'd0}) + $signed({18'd0, r3_pl[k]})
                             + PROD_W'(32768);
            end

            o_seg.visible <= r4_ok;
            if (r4_ok) begin
                o_seg.clipped_first_x  <= n5_c[0];
                o_seg.clipped_first_y  <= n5_c[1];
                o_seg.clipped_second_x <= n5_c[2];
                o_seg.clipped_second_y <= n5_c[3];
            end else begin
                o_seg.clipped_first_x  <= r4_side.seg.first_x;
                o_seg.clipped_first_y  <= r4_side.seg.first_y;
                o_seg.clipped_second_x <= r4_side.seg.second_x;
                o_seg.clipped_second_y <= r4_side.seg.second_y;
            end
        end
    end

    assign o_vld = r5_vld;

endmodule
`default_nettype wire

### hdl/lsw_checker.sv
// port level checks for the line segment window clipper, bound to the top level
// depends on lsw_pkg and line_segment_window_clip
`default_nettype none
module lsw_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input lsw_pkg::t_seg_out  o_out_data,
    input wire                pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind line_segment_window_clip lsw_checker u_lsw_checker (.*);
`default_nettype wire
